[rtl/snq_pkg.sv]
`default_nettype none

package snq_pkg;

  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned OFFSET_W  = 8;
  localparam int unsigned SCALE_W   = 4;
  localparam int unsigned SNAP_W    = 2;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned OCTAVE    = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 7;

  localparam logic [NOTE_W-1:0] NOTE_TOP = 7'd127;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_KEY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_MAX      = 3'd5;

  localparam logic [SNAP_W-1:0]  SNAP_MUTE  = 2'd0;
  localparam logic [SNAP_W-1:0]  SNAP_UP    = 2'd1;
  localparam logic [SNAP_W-1:0]  SNAP_DOWN  = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_OFF  = 4'd0;
  localparam logic               OP_FILTER  = 1'b0;
  localparam logic               OP_TRANSP  = 1'b1;

  // interval set per scale, bit i = semitone i above the root
  function automatic logic [OCTAVE-1:0] scale_mask(input logic [SCALE_W-1:0] sel);
    logic [OCTAVE-1:0] m;
    unique case (sel)
      4'd0:    m = 12'h000;
      4'd1:    m = 12'hAB5;
      4'd2:    m = 12'h5AD;
      4'd3:    m = 12'h6AD;
      4'd4:    m = 12'h5AB;
      4'd5:    m = 12'hAD5;
      4'd6:    m = 12'h6B5;
      4'd7:    m = 12'h56B;
      4'd8:    m = 12'h9AD;
      4'd9:    m = 12'hAAD;
      4'd10:   m = 12'h295;
      4'd11:   m = 12'h4A9;
      4'd12:   m = 12'h4E9;
      4'd13:   m = 12'h555;
      4'd14:   m = 12'hB6D;
      default: m = 12'hFFF;
    endcase
    return m;
  endfunction

  // 7-bit value mod 12 by conditional subtraction of 96, 48, 24, 12
  function automatic logic [PC_W-1:0] mod12(input logic [NOTE_W-1:0] n);
    logic [NOTE_W-1:0] v;
    v = n;
    if (v >= 7'd96) v = v - 7'd96;
    if (v >= 7'd48) v = v - 7'd48;
    if (v >= 7'd24) v = v - 7'd24;
    if (v >= 7'd12) v = v - 7'd12;
    return v[PC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/scale_note_quantizer.sv]
`default_nettype none

// Channel | Ports                                   | Direction | Handshake
// input   | in_note, in_offset, in_mode             | in        | in_valid / in_stall
// result  | out_note, out_muted                     | out       | out_valid / out_stall
// config  | cfg_wr_en, cfg_index, cfg_wdata         | in        | write on cfg_wr_en
//
// One note per cycle sustained while no stalled result holds the pipe.
// Stage 1 transposes and clamps, stage 2 rotates the scale mask by the root,
// stage 3 aligns a 13-bit window at the note's pitch class, stage 4 searches it.
// Reset (rst_n low, synchronous) empties the pipe and loads register defaults.
// A stalled result freezes the whole pipe; in_stall follows it combinationally.

module scale_note_quantizer (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [snq_pkg::NOTE_W-1:0]      in_note,
  input  wire  signed [snq_pkg::OFFSET_W-1:0] in_offset,
  input  wire                             in_mode,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [snq_pkg::NOTE_W-1:0]      out_note,
  output logic                            out_muted,
  input  wire                             cfg_wr_en,
  input  wire  [snq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [snq_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int unsigned NW = snq_pkg::NOTE_W;
  localparam int unsigned OC = snq_pkg::OCTAVE;
  localparam int unsigned PW = snq_pkg::PC_W;

  // ---------------- configuration registers ----------------
  logic                         filt_en_r;
  logic [snq_pkg::SCALE_W-1:0]  scale_sel_r;
  logic [NW-1:0]                root_key_r;
  logic [snq_pkg::SNAP_W-1:0]   snap_r;
  logic [NW-1:0]                note_min_r;
  logic [NW-1:0]                note_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_en_r   <= 1'b0;
      scale_sel_r <= snq_pkg::SCALE_OFF;
      root_key_r  <= '0;
      snap_r      <= snq_pkg::SNAP_MUTE;
      note_min_r  <= '0;
      note_max_r  <= snq_pkg::NOTE_TOP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        snq_pkg::REG_FILTER_ENABLE: filt_en_r   <= cfg_wdata[0];
        snq_pkg::REG_SCALE_SELECT:  scale_sel_r <= cfg_wdata[snq_pkg::SCALE_W-1:0];
        snq_pkg::REG_ROOT_KEY:      root_key_r  <= cfg_wdata[NW-1:0];
        snq_pkg::REG_SNAP_MODE:     snap_r      <= cfg_wdata[snq_pkg::SNAP_W-1:0];
        snq_pkg::REG_NOTE_MIN:      note_min_r  <= cfg_wdata[NW-1:0];
        snq_pkg::REG_NOTE_MAX:      note_max_r  <= cfg_wdata[NW-1:0];
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // whole pipe moves together; it holds only while a result waits
  logic adv;
  logic v1_r, v2_r, v3_r, out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // ---------------- stage 1: transpose, clamp, bypass decision ----------------
  logic signed [NW+1:0] sum;
  logic signed [NW+1:0] clamp_lo;
  logic [NW-1:0]        n1_nxt, n1_r;
  logic                 q1_nxt, q1_r;
  logic                 scale_on;

  assign scale_on = (scale_sel_r != snq_pkg::SCALE_OFF);

  always_comb begin
    sum      = $signed({2'b00, in_note}) + $signed({in_offset[snq_pkg::OFFSET_W-1], in_offset});
    // raise to note_min first, then lower to note_max
    clamp_lo = (sum < $signed({2'b00, note_min_r})) ? $signed({2'b00, note_min_r}) : sum;
    if (in_mode == snq_pkg::OP_TRANSP) begin
      n1_nxt = (clamp_lo > $signed({2'b00, note_max_r})) ? note_max_r : clamp_lo[NW-1:0];
      q1_nxt = scale_on;
    end else begin
      n1_nxt = in_note;
      q1_nxt = scale_on && filt_en_r;
    end
  end

  // ---------------- stage 2: pitch class and root-rotated mask ----------------
  logic [2*OC-1:0] mask_dbl;
  logic [OC-1:0]   rot_nxt, rot_r;
  logic [PW-1:0]   pc_nxt, pc_r;
  logic [NW-1:0]   n2_r;
  logic            q2_r;

  always_comb begin
    // rot[p] = mask[(p - root) mod 12]
    mask_dbl = {snq_pkg::scale_mask(scale_sel_r), snq_pkg::scale_mask(scale_sel_r)}
               << snq_pkg::mod12(root_key_r);
    rot_nxt  = mask_dbl[2*OC-1:OC];
    pc_nxt   = snq_pkg::mod12(n1_r);
  end

  // ---------------- stage 3: window around the pitch class ----------------
  // win[d] = in-scale flag of pc+d; win[OC-d] = flag of pc-d
  logic [2*OC-1:0] rot_dbl;
  logic [OC:0]     win_nxt, win_r;
  logic [NW-1:0]   n3_r;
  logic            q3_r;

  always_comb begin
    rot_dbl = {rot_r, rot_r} >> pc_r;
    win_nxt = rot_dbl[OC:0];
  end

  // ---------------- stage 4: nearest in-scale search ----------------
  logic [PW-1:0]  d_up, d_dn;
  logic           f_up, f_dn;
  logic [NW:0]    up_sum;
  logic [NW-1:0]  note_nxt;
  logic           muted_nxt;

  always_comb begin
    f_up = 1'b0;
    f_dn = 1'b0;
    d_up = '0;
    d_dn = '0;
    // descending scan so the smallest distance wins
    for (int d = OC; d >= 1; d--) begin
      if (win_r[d]) begin
        f_up = 1'b1;
        d_up = PW'(d);
      end
      if (win_r[OC-d]) begin
        f_dn = 1'b1;
        d_dn = PW'(d);
      end
    end
    up_sum = {1'b0, n3_r} + {{(NW+1-PW){1'b0}}, d_up};

    note_nxt  = n3_r;
    muted_nxt = 1'b0;
    if (q3_r && !win_r[0]) begin
      priority if (snap_r == snq_pkg::SNAP_UP) begin
        if (f_up && (up_sum <= {1'b0, snq_pkg::NOTE_TOP})) note_nxt = up_sum[NW-1:0];
        else muted_nxt = 1'b1;
      end else if (snap_r == snq_pkg::SNAP_DOWN) begin
        if (f_dn && (n3_r >= {{(NW-PW){1'b0}}, d_dn}))
          note_nxt = n3_r - {{(NW-PW){1'b0}}, d_dn};
        else muted_nxt = 1'b1;
      end else begin
        muted_nxt = 1'b1;  // mute, including the unused snap code
      end
    end
  end

  // ---------------- payload registers ----------------
  logic [NW-1:0] out_note_r;
  logic          out_muted_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r        <= n1_nxt;
      q1_r        <= q1_nxt;
      n2_r        <= n1_r;
      q2_r        <= q1_r;
      rot_r       <= rot_nxt;
      pc_r        <= pc_nxt;
      n3_r        <= n2_r;
      q3_r        <= q2_r;
      win_r       <= win_nxt;
      out_note_r  <= note_nxt;
      out_muted_r <= muted_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_note  = out_note_r;
  assign out_muted = out_muted_r;

  // ---------------- assertions ----------------
  // a mute can only come from an active scale (the user must keep config static while busy)
  a_mute_needs_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_muted_r |-> scale_on)
    else $error("muted result with scale off");

  // a waiting result freezes every stage
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable({v1_r, v2_r, v3_r}))
    else $error("pipe moved during output stall");

  // a new result only appears from a valid stage-3 item
  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result without stage-3 item");

endmodule

`default_nettype wire

[verif/scale_note_quantizer_test.sv]
module scale_note_quantizer_test;
  import snq_pkg::*;

  // Cycle budget for the whole run, sized for every gap and stall at its longest.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 14;
  localparam int NOTES_PER_PHASE = 125;
  localparam int TAIL_CYCLES = 8;

  // Scale codes used by name below (beyond the package's SCALE_OFF).
  localparam logic [SCALE_W-1:0] SCALE_MAJOR      = 4'd1;
  localparam logic [SCALE_W-1:0] SCALE_MINOR      = 4'd2;
  localparam logic [SCALE_W-1:0] SCALE_DIMINISHED = 4'd14;
  localparam logic [SCALE_W-1:0] SCALE_CHROMATIC  = 4'd15;
  localparam logic [SNAP_W-1:0]  SNAP_UNUSED      = 2'd3;

  // Interval sets, 12 bits per scale code, code 0 in the low bits.
  // Bit k set means k semitones above the root is in the scale.
  localparam logic [16*OCTAVE-1:0] KEY_SETS = {
    12'hFFF, 12'hB6D, 12'h555, 12'h4E9, 12'h4A9, 12'h295, 12'hAAD, 12'h9AD,
    12'h56B, 12'h6B5, 12'hAD5, 12'h5AB, 12'h6AD, 12'h5AD, 12'hAB5, 12'h000
  };

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              muted;
  } voice_t;

  // Shadow of the six registers, in register order.
  typedef struct packed {
    logic               enable;
    logic [SCALE_W-1:0] scale;
    logic [NOTE_W-1:0]  root;
    logic [SNAP_W-1:0]  snap;
    logic [NOTE_W-1:0]  lo;
    logic [NOTE_W-1:0]  hi;
  } key_setup_t;

  // One directed row: which setup to run under, the note, and a typed-in answer
  // when the answer is obvious (known = 1); otherwise the predictor decides.
  typedef struct packed {
    logic [2:0]          setup;
    logic [NOTE_W-1:0]   note;
    logic [OFFSET_W-1:0] offset;
    logic                mode;
    logic                known;
    logic [NOTE_W-1:0]   want_note;
    logic                want_muted;
  } cue_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [NOTE_W-1:0]          in_note = '0;
  logic signed [OFFSET_W-1:0] in_offset = '0;
  logic                       in_mode = OP_FILTER;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [NOTE_W-1:0]          out_note;
  logic                       out_muted;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_FILTER_ENABLE;
  logic [CFG_DAT_W-1:0]       cfg_wdata = '0;

  // Typed-in answer travels with the payload so the monitor sees it at the
  // same edge the transaction is taken.
  logic   given_known = 1'b0;
  voice_t given_voice = '0;

  key_setup_t active_key = {1'b0, SCALE_OFF, 7'd0, SNAP_MUTE, 7'd0, 7'd127};
  voice_t     expected_voices [$];
  voice_t     want_voice;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int stall_hold = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int notes_taken = 0;
  int filter_ops = 0;
  int transpose_ops = 0;
  int muted_seen = 0;
  int settings_loaded = 0;

  cue_t       directed_cues [$];
  key_setup_t directed_keys [$];

  scale_note_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_note   (in_note),
    .in_offset (in_offset),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_note  (out_note),
    .out_muted (out_muted),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Pitch class relative to the root, looked up in the selected interval set.
  function automatic bit on_key(input int pitch, input key_setup_t k);
    int degree;
    logic [OCTAVE-1:0] set_bits;
    degree = ((pitch % OCTAVE) + OCTAVE - (k.root % OCTAVE)) % OCTAVE;
    set_bits = KEY_SETS[k.scale*OCTAVE +: OCTAVE];
    return set_bits[degree];
  endfunction

  function automatic voice_t predict_voice(input logic [NOTE_W-1:0] n,
                                           input logic signed [OFFSET_W-1:0] ofs,
                                           input logic m, input key_setup_t k);
    voice_t v;
    int pitch;
    int probe;
    int lo_lim;
    int hi_lim;
    int top;
    bit found;
    lo_lim = int'(k.lo);
    hi_lim = int'(k.hi);
    top = int'(NOTE_TOP);
    v.muted = 1'b0;
    if (m == OP_FILTER) begin
      pitch = int'(n);
      // bypass: filtering off or no scale
      if (!k.enable || k.scale == SCALE_OFF) begin
        v.note = n;
        return v;
      end
    end else begin
      // raise to the low limit first, then cut to the high one; inverted limits give hi
      pitch = int'(n) + int'(ofs);
      if (pitch < lo_lim) pitch = lo_lim;
      if (pitch > hi_lim) pitch = hi_lim;
      if (k.scale == SCALE_OFF) begin
        v.note = pitch[NOTE_W-1:0];
        return v;
      end
    end
    v.note = pitch[NOTE_W-1:0];
    if (on_key(pitch, k)) return v;
    found = 1'b0;
    // search ignores the clamp limits; the unused snap code mutes
    if (k.snap == SNAP_UP) begin
      for (probe = pitch + 1; probe <= top && !found; probe++)
        if (on_key(probe, k)) begin
          found = 1'b1;
          v.note = probe[NOTE_W-1:0];
        end
    end else if (k.snap == SNAP_DOWN) begin
      for (probe = pitch - 1; probe >= 0 && !found; probe--)
        if (on_key(probe, k)) begin
          found = 1'b1;
          v.note = probe[NOTE_W-1:0];
        end
    end
    v.muted = !found;
    return v;
  endfunction

  // Most gaps short, a few long.
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor, checker and watchdog. Outputs are checked before the input side
  // is sampled so a same-edge push/pop never depends on process order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_voices.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_voices.size() == 0) begin
          report_mismatch($sformatf("result note %0d muted %0b with nothing expected",
                                    out_note, out_muted));
        end else begin
          want_voice = expected_voices.pop_front();
          if (out_note !== want_voice.note)
            report_mismatch($sformatf("out_note %0d, expected %0d",
                                      out_note, want_voice.note));
          if (out_muted !== want_voice.muted)
            report_mismatch($sformatf("out_muted %0b, expected %0b (note %0d)",
                                      out_muted, want_voice.muted, want_voice.note));
        end
        if (out_muted === 1'b1) muted_seen++;
      end
      if (in_valid && !in_stall) begin
        if (given_known)
          expected_voices.push_back(given_voice);
        else
          expected_voices.push_back(predict_voice(in_note, in_offset, in_mode, active_key));
        notes_taken++;
        if (in_mode == OP_FILTER) filter_ops++;
        else transpose_ops++;
      end
    end
  end

  // Result-side back-pressure: stall bursts of random length; no new burst starts when rx_steady.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!out_stall && !rx_steady && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= idle_span();
    end else begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 4);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present one transaction, hold it until taken, then maybe go idle a while.
  task automatic play_note(input logic [NOTE_W-1:0] n, input logic [OFFSET_W-1:0] ofs,
                           input logic m, input logic known, input voice_t answer);
    int gap;
    in_valid <= 1'b1;
    in_note <= n;
    in_offset <= ofs;
    in_mode <= m;
    given_known <= known;
    given_voice <= answer;
    do @(posedge clk); while (in_stall);
    gap = tx_steady ? 0 : idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result. Each note gives
  // exactly one result, so an empty queue means an empty pipe.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_voices.size() != 0);
  endtask

  // Write all six registers back to back; only called with the pipe empty.
  task automatic load_setting(input key_setup_t k);
    logic [CFG_IDX_W-1:0] slot [6];
    logic [CFG_DAT_W-1:0] field_val [6];
    int i;
    slot[0] = REG_FILTER_ENABLE;  field_val[0] = CFG_DAT_W'(k.enable);
    slot[1] = REG_SCALE_SELECT;   field_val[1] = CFG_DAT_W'(k.scale);
    slot[2] = REG_ROOT_KEY;       field_val[2] = k.root;
    slot[3] = REG_SNAP_MODE;      field_val[3] = CFG_DAT_W'(k.snap);
    slot[4] = REG_NOTE_MIN;       field_val[4] = k.lo;
    slot[5] = REG_NOTE_MAX;       field_val[5] = k.hi;
    for (i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= slot[i];
      cfg_wdata <= field_val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    active_key = k;
    settings_loaded++;
  endtask

  initial begin
    int phase;
    int k;
    int pick;
    int cur_setup;
    key_setup_t rnd_key;
    logic [NOTE_W-1:0] rnd_note;
    logic [OFFSET_W-1:0] rnd_offset;

    // Directed setups; setup 0 equals the reset state and is never written.
    directed_keys = '{
      {1'b0, SCALE_OFF,        7'd0,   SNAP_MUTE,   7'd0,   7'd127},
      {1'b1, SCALE_MAJOR,      7'd0,   SNAP_MUTE,   7'd0,   7'd127},
      {1'b1, SCALE_MAJOR,      7'd13,  SNAP_UP,     7'd0,   7'd127},  // root wraps to C#
      {1'b1, SCALE_MAJOR,      7'd122, SNAP_DOWN,   7'd0,   7'd127},  // root wraps to D
      {1'b0, SCALE_OFF,        7'd0,   SNAP_MUTE,   7'd100, 7'd20},   // inverted limits
      {1'b0, SCALE_MINOR,      7'd127, SNAP_DOWN,   7'd10,  7'd110},  // filter off, scale on
      {1'b1, SCALE_DIMINISHED, 7'd5,   SNAP_UNUSED, 7'd0,   7'd127},
      {1'b1, SCALE_CHROMATIC,  7'd127, SNAP_UP,     7'd127, 7'd127}
    };

    //            setup note     offset  mode       known want    muted
    directed_cues = '{
      {3'd0, 7'd0,   8'h00, OP_FILTER, 1'b1, 7'd0,   1'b0},
      {3'd0, 7'd127, 8'hFF, OP_FILTER, 1'b1, 7'd127, 1'b0},  // offset unused in filter
      {3'd0, 7'd127, 8'h7F, OP_TRANSP, 1'b1, 7'd127, 1'b0},  // clamps at top
      {3'd0, 7'd0,   8'h80, OP_TRANSP, 1'b1, 7'd0,   1'b0},  // -128 clamps at bottom
      {3'd0, 7'd127, 8'h80, OP_TRANSP, 1'b1, 7'd0,   1'b0},  // sum -1
      {3'd0, 7'd60,  8'h7F, OP_TRANSP, 1'b1, 7'd127, 1'b0},
      {3'd0, 7'd64,  8'hFB, OP_TRANSP, 1'b1, 7'd59,  1'b0},  // -5
      {3'd1, 7'd61,  8'h00, OP_FILTER, 1'b1, 7'd61,  1'b1},  // C# not in C major
      {3'd1, 7'd60,  8'h00, OP_FILTER, 1'b1, 7'd60,  1'b0},
      {3'd1, 7'd60,  8'h01, OP_TRANSP, 1'b1, 7'd61,  1'b1},
      {3'd2, 7'd127, 8'h00, OP_FILTER, 1'b1, 7'd127, 1'b1},  // nothing above to snap to
      {3'd2, 7'd0,   8'h00, OP_FILTER, 1'b0, 7'd0,   1'b0},
      {3'd2, 7'd2,   8'h00, OP_FILTER, 1'b0, 7'd0,   1'b0},
      {3'd3, 7'd0,   8'h00, OP_FILTER, 1'b1, 7'd0,   1'b1},  // nothing below to snap to
      {3'd3, 7'd127, 8'h00, OP_FILTER, 1'b0, 7'd0,   1'b0},
      {3'd3, 7'd50,  8'hF9, OP_TRANSP, 1'b0, 7'd0,   1'b0},
      {3'd4, 7'd0,   8'h00, OP_TRANSP, 1'b1, 7'd20,  1'b0},
      {3'd4, 7'd127, 8'h7F, OP_TRANSP, 1'b1, 7'd20,  1'b0},
      {3'd4, 7'd55,  8'h00, OP_FILTER, 1'b1, 7'd55,  1'b0},
      {3'd5, 7'd61,  8'h00, OP_FILTER, 1'b1, 7'd61,  1'b0},  // bypass, enable low
      {3'd5, 7'd0,   8'h80, OP_TRANSP, 1'b0, 7'd0,   1'b0},  // transpose ignores enable
      {3'd5, 7'd127, 8'h7F, OP_TRANSP, 1'b0, 7'd0,   1'b0},
      {3'd6, 7'd63,  8'h00, OP_FILTER, 1'b1, 7'd63,  1'b1},  // unused snap code mutes
      {3'd6, 7'd64,  8'h00, OP_FILTER, 1'b0, 7'd0,   1'b0},
      {3'd7, 7'd0,   8'h00, OP_TRANSP, 1'b1, 7'd127, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    cur_setup = 0;
    foreach (directed_cues[i]) begin
      if (directed_cues[i].setup != cur_setup) begin
        settle();
        load_setting(directed_keys[directed_cues[i].setup]);
        cur_setup = directed_cues[i].setup;
      end
      play_note(directed_cues[i].note, directed_cues[i].offset, directed_cues[i].mode,
                directed_cues[i].known,
                {directed_cues[i].want_note, directed_cues[i].want_muted});
    end

    // Random part: one register setting per phase, written with the pipe empty.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        rnd_key = {1'b1, SCALE_CHROMATIC, 7'd127, SNAP_UNUSED, 7'd127, 7'd127};
      end else if (phase == 1) begin
        rnd_key = {1'b0, SCALE_OFF, 7'd0, SNAP_MUTE, 7'd0, 7'd0};
      end else begin
        rnd_key.enable = ($urandom_range(0, 3) != 0);
        rnd_key.scale = SCALE_W'($urandom_range(0, 15));
        rnd_key.root = NOTE_W'($urandom_range(0, 127));
        rnd_key.snap = SNAP_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          rnd_key.lo = NOTE_W'($urandom_range(0, 64));
          rnd_key.hi = NOTE_W'($urandom_range(rnd_key.lo, 127));
        end else if (pick < 8) begin
          rnd_key.lo = 7'd0;
          rnd_key.hi = 7'd127;
        end else begin
          rnd_key.lo = NOTE_W'($urandom_range(0, 127));
          rnd_key.hi = NOTE_W'($urandom_range(0, 127));
        end
      end
      load_setting(rnd_key);

      // some phases run back to back on one side or both
      tx_steady = (phase % 4 == 2);
      rx_steady = (phase % 3 == 2);

      for (k = 0; k < NOTES_PER_PHASE; k++) begin
        // hold off mid-phase until everything has drained
        if (k == NOTES_PER_PHASE / 2 && phase % 5 == 4) settle();
        pick = $urandom_range(0, 9);
        if (pick == 0) rnd_note = 7'd0;
        else if (pick == 1) rnd_note = NOTE_TOP;
        else rnd_note = NOTE_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        if (pick == 0) rnd_offset = 8'h80;
        else if (pick == 1) rnd_offset = 8'h7F;
        else if (pick < 5) rnd_offset = OFFSET_W'($urandom_range(0, 24) - 12);
        else rnd_offset = OFFSET_W'($urandom_range(0, 255));
        play_note(rnd_note, rnd_offset, 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    settle();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d notes (%0d filter, %0d transpose) under %0d register settings",
             notes_taken, filter_ops, transpose_ops, settings_loaded + 1);
    $display("%0d results came back muted, %0d mismatches", muted_seen, fail_count);
    if (fail_count == 0 && expected_voices.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
